// ===== rtl/cba_pkg.sv =====
package cba_pkg;

	// request codes
	localparam logic [2:0] REQ_INIT        = 3'd0;
	localparam logic [2:0] REQ_BLOCK_ALLOC = 3'd1;
	localparam logic [2:0] REQ_BLOCK_FREE  = 3'd2;
	localparam logic [2:0] REQ_SPACE_ALLOC = 3'd3;
	localparam logic [2:0] REQ_SPACE_FREE  = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TOO_BIG = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_BASE_SPACE    = 2'd0;
	localparam logic [1:0] CFG_FREE_CODE     = 2'd1;
	localparam logic [1:0] CFG_BLOCKS_CODE   = 2'd2;
	localparam logic [1:0] CFG_RESERVED_CODE = 2'd3;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0] req;
		logic [7:0] tag;
		logic [7:0] count;    // 1..127, zero already mapped to one
		logic [3:0] sidx;
		logic [5:0] bidx;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] fs;
		logic [5:0] fb;
	} rsp_t;

	typedef enum logic [3:0] {
		E_IDLE,
		E_INIT,
		E_FILL,
		E_SCAN_SPACE,
		E_SCAN_RD,
		E_SCAN_WAIT,
		E_SCAN_BLK,
		E_TAG,
		E_NEWSPACE,
		E_BFREE,
		E_DONE
	} eng_state_t;

endpackage

// ===== rtl/cba_ram.sv =====
module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cba_front.sv =====
module cba_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    req_type,
	input  logic [7:0]    type_tag,
	input  logic [6:0]    block_count,
	input  logic [3:0]    space_index,
	input  logic [5:0]    block_index,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output cba_pkg::cmd_t cmd
);
	// two-entry queue of classified requests
	cba_pkg::cmd_t q_q [2];
	logic          rd_q, wr_q;
	logic [1:0]    cnt_q;
	cba_pkg::cmd_t c;

	// classify: map a count of zero to one
	always_comb begin
		c.req   = req_type;
		c.tag   = type_tag;
		c.count = (block_count == 7'd0) ? 8'd1 : {1'b0, block_count};
		c.sidx  = space_index;
		c.bidx  = block_index;
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_q[rd_q];

	// payload writes
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			q_q[wr_q] <= c;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wr_q <= ~wr_q;
			end
			if (cmd_valid && cmd_ready) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end
endmodule

// ===== rtl/cba_engine.sv =====
module cba_engine #(
	parameter int NUM_SPACES = 16,
	parameter int BLOCKS_PER_SPACE_N = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [3:0]    base_space,
	input  logic [7:0]    free_code,
	input  logic [7:0]    blocks_code,
	input  logic [7:0]    reserved_code,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  cba_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cba_pkg::rsp_t rsp
);
	localparam int SW = (NUM_SPACES > 1) ? $clog2(NUM_SPACES) : 1;
	localparam int BW = $clog2(BLOCKS_PER_SPACE_N);
	localparam int AW = SW + BW;
	localparam int CW = ($clog2(BLOCKS_PER_SPACE_N + 1) + 1 > 8) ?
		$clog2(BLOCKS_PER_SPACE_N + 1) + 1 : 8;

	cba_pkg::eng_state_t state_q, state_d;

	logic [7:0]    kind_q [NUM_SPACES];
	logic          inited_q;
	cba_pkg::cmd_t cmd_q;
	logic [SW:0]   s_q;        // space counter, one bit to hold NUM_SPACES
	logic [BW:0]   b_q;        // block counter
	logic [CW-1:0] run_q;
	logic [BW:0]   end_q;
	logic [SW-1:0] fs_q;
	cba_pkg::rsp_t rsp_q;
	cba_pkg::rsp_t out_q;
	logic          rsp_valid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic          ff_hit;
	logic [SW-1:0] ff_idx;
	logic [CW-1:0] cnt_ext;
	logic [CW-1:0] run_nx;
	logic          base_ok;
	logic          bfree_ok;
	logic          too_big;
	logic          done_fire;

	cba_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_tags (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// first free space over the small kind table
	always_comb begin
		ff_hit = 1'b0;
		ff_idx = '0;
		for (int i = NUM_SPACES - 1; i >= 0; i--) begin
			if (kind_q[i] == free_code) begin
				ff_hit = 1'b1;
				ff_idx = SW'(i);
			end
		end
	end

	assign cnt_ext   = CW'(cmd_q.count);
	assign run_nx    = (rdata == free_code) ? run_q + 1'b1 : '0;
	assign base_ok   = (int'(base_space) < NUM_SPACES);
	assign bfree_ok  = (int'(cmd_q.sidx) < NUM_SPACES) &&
		(int'(cmd_q.bidx) < BLOCKS_PER_SPACE_N);
	assign too_big   = (cnt_ext > CW'(BLOCKS_PER_SPACE_N));
	assign done_fire = (state_q == cba_pkg::E_DONE) && (!rsp_valid_q || rsp_ready);
	assign cmd_ready = (state_q == cba_pkg::E_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = out_q;
	assign raddr     = {s_q[SW-1:0], b_q[BW-1:0]};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cba_pkg::E_IDLE: begin
				if (cmd_valid) begin
					state_d = cba_pkg::E_INIT;
				end
			end
			cba_pkg::E_INIT: begin
				if (!inited_q && (cmd_q.req == cba_pkg::REQ_INIT ||
						cmd_q.req == cba_pkg::REQ_BLOCK_ALLOC)) begin
					if (base_ok) begin
						state_d = cba_pkg::E_FILL;
					end else begin
						state_d = (cmd_q.req == cba_pkg::REQ_BLOCK_ALLOC) ?
							cba_pkg::E_SCAN_SPACE : cba_pkg::E_DONE;
					end
				end else begin
					case (cmd_q.req)
						cba_pkg::REQ_BLOCK_ALLOC: state_d = cba_pkg::E_SCAN_SPACE;
						cba_pkg::REQ_BLOCK_FREE:
							state_d = bfree_ok ? cba_pkg::E_BFREE : cba_pkg::E_DONE;
						default:                  state_d = cba_pkg::E_DONE;
					endcase
				end
			end
			cba_pkg::E_FILL: begin
				if (b_q == (BW+1)'(BLOCKS_PER_SPACE_N - 1)) begin
					state_d = (cmd_q.req == cba_pkg::REQ_BLOCK_ALLOC) ?
						cba_pkg::E_SCAN_SPACE : cba_pkg::E_DONE;
				end
			end
			cba_pkg::E_SCAN_SPACE: begin
				if (too_big) begin
					state_d = cba_pkg::E_DONE;
				end else if (s_q == (SW+1)'(NUM_SPACES)) begin
					state_d = ff_hit ? cba_pkg::E_NEWSPACE : cba_pkg::E_DONE;
				end else if (kind_q[s_q[SW-1:0]] == blocks_code) begin
					state_d = cba_pkg::E_SCAN_WAIT;
				end
			end
			cba_pkg::E_SCAN_WAIT: state_d = cba_pkg::E_SCAN_BLK;
			cba_pkg::E_SCAN_BLK: begin
				if (run_nx >= cnt_ext) begin
					state_d = cba_pkg::E_TAG;
				end else if (b_q == (BW+1)'(BLOCKS_PER_SPACE_N - 1)) begin
					state_d = cba_pkg::E_SCAN_SPACE;
				end else begin
					state_d = cba_pkg::E_SCAN_WAIT;
				end
			end
			cba_pkg::E_TAG: begin
				if (b_q == end_q) begin
					state_d = cba_pkg::E_DONE;
				end
			end
			cba_pkg::E_NEWSPACE: begin
				if (b_q == (BW+1)'(BLOCKS_PER_SPACE_N - 1)) begin
					state_d = cba_pkg::E_DONE;
				end
			end
			cba_pkg::E_BFREE: begin
				if (b_q >= (BW+1)'(BLOCKS_PER_SPACE_N - 1) || run_q == cnt_ext - 1'b1) begin
					state_d = cba_pkg::E_DONE;
				end
			end
			cba_pkg::E_DONE: begin
				if (done_fire) begin
					state_d = cba_pkg::E_IDLE;
				end
			end
			default: state_d = cba_pkg::E_IDLE;
		endcase
	end

	// tag memory writes
	always_comb begin
		we    = 1'b0;
		waddr = raddr;
		wdata = free_code;
		case (state_q)
			cba_pkg::E_FILL:     we = 1'b1;
			cba_pkg::E_TAG: begin
				we    = 1'b1;
				wdata = cmd_q.tag;
			end
			cba_pkg::E_NEWSPACE: begin
				we    = 1'b1;
				waddr = {fs_q, b_q[BW-1:0]};
				wdata = (CW'(b_q) < cnt_ext) ? cmd_q.tag : free_code;
			end
			cba_pkg::E_BFREE:    we = (b_q < (BW+1)'(BLOCKS_PER_SPACE_N));
			default:             we = 1'b0;
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cba_pkg::E_IDLE;
			inited_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_SPACES; i++) begin
				kind_q[i] <= 8'd0;
			end
		end else begin
			state_q <= state_d;
			// hand the finished result to the output register
			if (done_fire) begin
				rsp_valid_q <= 1'b1;
				out_q       <= rsp_q;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				cba_pkg::E_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						rsp_q   <= '0;
						s_q     <= '0;
						b_q     <= '0;
						run_q   <= '0;
						end_q   <= '0;
						fs_q    <= '0;
					end
				end
				cba_pkg::E_INIT: begin
					if (!inited_q && (cmd_q.req == cba_pkg::REQ_INIT ||
							cmd_q.req == cba_pkg::REQ_BLOCK_ALLOC)) begin
						inited_q <= 1'b1;
						for (int i = 0; i < NUM_SPACES; i++) begin
							if (i < int'(base_space)) begin
								kind_q[i] <= reserved_code;
							end else if (i == int'(base_space)) begin
								kind_q[i] <= blocks_code;
							end else begin
								kind_q[i] <= free_code;
							end
						end
						s_q <= base_ok ? (SW+1)'(base_space) : '0;
						b_q <= '0;
					end else begin
						case (cmd_q.req)
							cba_pkg::REQ_SPACE_ALLOC: begin
								if (ff_hit) begin
									kind_q[ff_idx] <= cmd_q.tag;
									rsp_q.fs       <= 4'(ff_idx);
								end else begin
									rsp_q.status   <= cba_pkg::ST_FULL;
								end
							end
							cba_pkg::REQ_SPACE_FREE: begin
								if (int'(cmd_q.sidx) < NUM_SPACES) begin
									kind_q[SW'(cmd_q.sidx)] <= free_code;
								end
							end
							cba_pkg::REQ_BLOCK_FREE: begin
								s_q   <= (SW+1)'(cmd_q.sidx);
								b_q   <= (BW+1)'(cmd_q.bidx);
								run_q <= '0;
							end
							default: ;
						endcase
					end
				end
				cba_pkg::E_FILL: begin
					if (b_q == (BW+1)'(BLOCKS_PER_SPACE_N - 1)) begin
						s_q <= '0;
						b_q <= '0;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				cba_pkg::E_SCAN_SPACE: begin
					b_q   <= '0;
					run_q <= '0;
					if (too_big) begin
						rsp_q.status <= cba_pkg::ST_TOO_BIG;
					end else if (s_q == (SW+1)'(NUM_SPACES)) begin
						if (ff_hit) begin
							kind_q[ff_idx] <= blocks_code;
							fs_q           <= ff_idx;
							rsp_q.fs       <= 4'(ff_idx);
						end else begin
							rsp_q.status   <= cba_pkg::ST_FULL;
						end
					end else if (kind_q[s_q[SW-1:0]] != blocks_code) begin
						s_q <= s_q + 1'b1;
					end
				end
				cba_pkg::E_SCAN_BLK: begin
					run_q <= run_nx;
					if (run_nx >= cnt_ext) begin
						b_q      <= (BW+1)'(b_q + 1'b1 - (BW+1)'(cnt_ext));
						end_q    <= b_q;
						rsp_q.fs <= 4'(s_q[SW-1:0]);
						rsp_q.fb <= 6'((BW+1)'(b_q + 1'b1 - (BW+1)'(cnt_ext)));
					end else if (b_q == (BW+1)'(BLOCKS_PER_SPACE_N - 1)) begin
						s_q <= s_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end
				cba_pkg::E_TAG, cba_pkg::E_NEWSPACE: begin
					b_q <= b_q + 1'b1;
				end
				cba_pkg::E_BFREE: begin
					b_q   <= b_q + 1'b1;
					run_q <= run_q + 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/contiguous_block_allocator.sv =====
// channel | dir | handshake          | payload
// s_axis  | in  | tvalid/tready      | tdata: req_type, type_tag, block_count, space_index, block_index
// m_axis  | out | tvalid/tready      | tdata: status, found_space, found_block
// cfg     | in  | cfg_we             | cfg_index selects register, cfg_data value
// A result for space requests, repeated init and unknown codes needs no table walk; block
// free clears the given blocks in turn, and a first init fills the base space with the free code.
// Block alloc visits the spaces, reads the tags of each block space (registered read) and tags
// the run it finds, or claims a free space as a new block space and fills it.
// A two-entry queue takes requests while the engine works; the engine stalls in its last step
// only while an earlier result still waits in the output register. Reset clears the space
// table, init flag and queue; tag memory is unset.
module contiguous_block_allocator #(
	parameter int NUM_SPACES = 16,
	parameter int BLOCKS_PER_SPACE_N = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // req_type, type_tag, block_count, space_index, block_index, pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // status, found_space, found_block, pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	logic [3:0] base_space_q;
	logic [7:0] free_code_q, blocks_code_q, reserved_code_q;
	logic          cmd_valid, cmd_ready;
	cba_pkg::cmd_t cmd;
	cba_pkg::rsp_t rsp;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_space_q    <= 4'd1;
			free_code_q     <= 8'd0;
			blocks_code_q   <= 8'd1;
			reserved_code_q <= 8'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				cba_pkg::CFG_BASE_SPACE:    base_space_q    <= cfg_data[3:0];
				cba_pkg::CFG_FREE_CODE:     free_code_q     <= cfg_data;
				cba_pkg::CFG_BLOCKS_CODE:   blocks_code_q   <= cfg_data;
				cba_pkg::CFG_RESERVED_CODE: reserved_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cba_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.req_type(s_axis_tdata[2:0]), .type_tag(s_axis_tdata[10:3]),
		.block_count(s_axis_tdata[17:11]), .space_index(s_axis_tdata[21:18]),
		.block_index(s_axis_tdata[27:22]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	cba_engine #(.NUM_SPACES(NUM_SPACES), .BLOCKS_PER_SPACE_N(BLOCKS_PER_SPACE_N)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.base_space(base_space_q), .free_code(free_code_q),
		.blocks_code(blocks_code_q), .reserved_code(reserved_code_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
	);

	assign m_axis_tdata = {4'd0, rsp.fb, rsp.fs, rsp.status};

	// status is never an undefined code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[1:0] <= cba_pkg::ST_FULL))
		else $error("bad status code");

	// an error result carries zero found fields
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[1:0] != cba_pkg::ST_OK) |-> (m_axis_tdata[11:2] == 10'd0))
		else $error("error result with nonzero fields");

	// engine leaves idle after it takes a command
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ready && cmd_valid) |=> !cmd_ready)
		else $error("engine did not start");
endmodule

// ===== dv/contiguous_block_allocator_tb.sv =====
module contiguous_block_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SPACES = 16;
	localparam int ROW    = 64;

	// request codes the block does not define
	localparam logic [2:0] REQ_SPARE_0 = 3'd5;
	localparam logic [2:0] REQ_SPARE_1 = 3'd6;
	localparam logic [2:0] REQ_SPARE_2 = 3'd7;

	typedef struct {
		logic [2:0] req;
		logic [7:0] tag;
		logic [6:0] count;
		logic [3:0] sidx;
		logic [5:0] bidx;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [3:0] fs;
		logic [5:0] fb;
	} grant_t;

	// Tracks the allocator's tables and the grants still owed
	class alloc_scoreboard;
		logic [7:0] kind [SPACES];
		logic [7:0] tags [SPACES*ROW];
		bit         set  [SPACES*ROW];
		bit         inited;
		logic [3:0] fbs;
		logic [7:0] free_c, blocks_c, reserved_c;
		grant_t     owed [$];
		int         fails, checked, n_ok, n_big, n_full;

		function new();
			foreach (kind[i]) kind[i] = 8'd0;
			foreach (tags[i]) begin
				tags[i] = 8'd0;
				set[i]  = 1'b0;
			end
			inited = 0;
			fbs = 4'd1; free_c = 8'd0; blocks_c = 8'd1; reserved_c = 8'd2;
		endfunction

		function void set_reg(logic [1:0] idx, logic [7:0] val);
			case (idx)
				cba_pkg::CFG_BASE_SPACE:    fbs = val[3:0];
				cba_pkg::CFG_FREE_CODE:     free_c = val;
				cba_pkg::CFG_BLOCKS_CODE:   blocks_c = val;
				cba_pkg::CFG_RESERVED_CODE: reserved_c = val;
				default: ;
			endcase
		endfunction

		function void put_tag(int s, int b, logic [7:0] t);
			tags[s*ROW+b] = t;
			set[s*ROW+b]  = 1'b1;
		endfunction

		function void run_init();
			if (inited) return;
			inited = 1;
			for (int i = 0; i < SPACES; i++) begin
				if (i < fbs) kind[i] = reserved_c;
				else if (i == fbs) begin
					kind[i] = blocks_c;
					for (int b = 0; b < ROW; b++) put_tag(i, b, free_c);
				end else kind[i] = free_c;
			end
		endfunction

		// First block space (as seen after init) holding a never-written tag, else -1
		function int unset_space();
			logic [7:0] k;
			for (int s = 0; s < SPACES; s++) begin
				if (inited) k = kind[s];
				else k = (s < fbs) ? reserved_c : (s == fbs) ? blocks_c : free_c;
				if (k != blocks_c || (!inited && s == fbs)) continue;
				for (int b = 0; b < ROW; b++)
					if (!set[s*ROW+b]) return s;
			end
			return -1;
		endfunction

		function int first_free();
			for (int i = 0; i < SPACES; i++)
				if (kind[i] == free_c) return i;
			return -1;
		endfunction

		// Work out the grant for one accepted request
		function void note_request(request_t r);
			grant_t g;
			int cnt, s, run;
			bit done;
			g = '{cba_pkg::ST_OK, 4'd0, 6'd0};
			cnt = (r.count == 0) ? 1 : int'(r.count);
			case (r.req)
				cba_pkg::REQ_INIT: run_init();
				cba_pkg::REQ_BLOCK_ALLOC: begin
					run_init();
					if (cnt > ROW) g.status = cba_pkg::ST_TOO_BIG;
					else begin
						done = 0;
						for (s = 0; s < SPACES && !done; s++) begin
							if (kind[s] != blocks_c) continue;
							run = 0;
							for (int b = 0; b < ROW; b++) begin
								if (tags[s*ROW+b] == free_c) begin
									run++;
									if (run >= cnt) begin
										for (int k = b + 1 - cnt; k <= b; k++)
											put_tag(s, k, r.tag);
										g.fs = 4'(s);
										g.fb = 6'(b + 1 - cnt);
										done = 1;
										break;
									end
								end else run = 0;
							end
						end
						if (!done) begin
							s = first_free();
							if (s >= 0) begin
								kind[s] = blocks_c;
								for (int b = 0; b < ROW; b++)
									put_tag(s, b, (b < cnt) ? r.tag : free_c);
								g.fs = 4'(s);
							end else g.status = cba_pkg::ST_FULL;
						end
					end
				end
				cba_pkg::REQ_BLOCK_FREE:
					for (int b = 0; b < cnt; b++)
						if (int'(r.bidx) + b < ROW) put_tag(r.sidx, int'(r.bidx) + b, free_c);
				cba_pkg::REQ_SPACE_ALLOC: begin
					s = first_free();
					if (s >= 0) begin
						kind[s] = r.tag;
						g.fs = 4'(s);
					end else g.status = cba_pkg::ST_FULL;
				end
				cba_pkg::REQ_SPACE_FREE: kind[r.sidx] = free_c;
				default: ;
			endcase
			owed.push_back(g);
		endfunction

		function void check_grant(grant_t a);
			grant_t e;
			checked++;
			if (owed.size() == 0) begin
				$error("grant with nothing outstanding: status %0d space %0d block %0d",
					a.status, a.fs, a.fb);
				fails++;
				return;
			end
			e = owed.pop_front();
			case (e.status)
				cba_pkg::ST_OK: n_ok++;
				cba_pkg::ST_TOO_BIG: n_big++;
				default: n_full++;
			endcase
			if (a.status !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, a.status);
				fails++;
			end
			if (a.fs !== e.fs) begin
				$error("found_space: expected %0d, got %0d", e.fs, a.fs);
				fails++;
			end
			if (a.fb !== e.fb) begin
				$error("found_block: expected %0d, got %0d", e.fb, a.fb);
				fails++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	alloc_scoreboard sb = new();
	bit hold_req = 0;
	int sent = 0;

	contiguous_block_allocator dut (.*);

	always #4 clk = ~clk;

	initial begin
		#50ms;
		$display("contiguous_block_allocator: mismatch");
		$finish;
	end

	// Check every grant transaction
	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_grant('{m_axis_tdata[1:0], m_axis_tdata[5:2], m_axis_tdata[11:6]});

	// Drive tready: randomly chosen stall modes plus one long hold on request
	initial begin
		int mode, left;
		mode = 0; left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 120);
			end
			left--;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.owed.size() != 0) @(negedge clk);
	endtask

	// Offer one request; swap a block alloc that would scan unwritten tags
	task automatic send(request_t r);
		int s;
		if (r.req == cba_pkg::REQ_BLOCK_ALLOC) begin
			s = sb.unset_space();
			if (s >= 0) begin
				r.req  = sb.inited ? cba_pkg::REQ_SPACE_FREE : cba_pkg::REQ_INIT;
				r.sidx = 4'(s);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'd0, r.bidx, r.sidx, r.count, r.tag, r.req};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_request(r);
		sent++;
	endtask

	task automatic idle_gap(int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	function automatic request_t rand_request();
		request_t r;
		int p;
		r.tag  = 8'($urandom_range(0, 255));
		r.sidx = 4'($urandom_range(0, 15));
		r.bidx = 6'($urandom_range(0, 63));
		r.count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
			7'($urandom_range(0, 8));
		p = $urandom_range(0, 99);
		if (p < 42) r.req = cba_pkg::REQ_BLOCK_ALLOC;
		else if (p < 67) r.req = cba_pkg::REQ_BLOCK_FREE;
		else if (p < 77) r.req = cba_pkg::REQ_SPACE_ALLOC;
		else if (p < 90) r.req = cba_pkg::REQ_SPACE_FREE;
		else if (p < 96) r.req = cba_pkg::REQ_INIT;
		else r.req = 3'($urandom_range(REQ_SPARE_0, REQ_SPARE_2));
		return r;
	endfunction

	// Random traffic in bursts with gaps
	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && n > 0; i++, n--) send(rand_request());
			if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
		end
	endtask

	initial begin
		request_t d [$];
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Phase 1: last space as the only block space
		write_reg(cba_pkg::CFG_BASE_SPACE, 8'd15);
		write_reg(cba_pkg::CFG_FREE_CODE, 8'h00);
		write_reg(cba_pkg::CFG_BLOCKS_CODE, 8'hFF);
		write_reg(cba_pkg::CFG_RESERVED_CODE, 8'h80);
		d = '{
			'{cba_pkg::REQ_SPACE_ALLOC, 8'h11, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_SPACE_FREE, 8'h00, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_FREE, 8'h00, 7'd127, 4'd15, 6'd63},
			'{REQ_SPARE_2, 8'hFF, 7'd127, 4'd15, 6'd63},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h01, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_INIT, 8'h00, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h22, 7'd64, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h23, 7'd65, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h24, 7'd127, 4'd0, 6'd0},
			'{cba_pkg::REQ_SPACE_ALLOC, 8'h25, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_SPACE_FREE, 8'h00, 7'd0, 4'd3, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h26, 7'd64, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'hFF, 7'd63, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_FREE, 8'h00, 7'd127, 4'd15, 6'd63},
			'{cba_pkg::REQ_BLOCK_FREE, 8'h00, 7'd1, 4'd15, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h00, 7'd1, 4'd0, 6'd0},
			'{cba_pkg::REQ_SPACE_FREE, 8'h00, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_SPACE_ALLOC, 8'hFF, 7'd0, 4'd0, 6'd0},
			'{cba_pkg::REQ_BLOCK_ALLOC, 8'h33, 7'd2, 4'd0, 6'd0},
			'{REQ_SPARE_0, 8'h00, 7'd0, 4'd0, 6'd0},
			'{REQ_SPARE_1, 8'h00, 7'd0, 4'd0, 6'd0}
		};
		foreach (d[i]) send(d[i]);
		random_phase(120);
		wait_drained();

		// Phase 2: free code at its top; long receiver hold while sending
		write_reg(cba_pkg::CFG_FREE_CODE, 8'hFF);
		hold_req = 1;
		for (int i = 0; i < 20; i++) send(rand_request());
		random_phase(110);
		wait_drained();

		// Phase 3: lowest block space index and swapped codes
		write_reg(cba_pkg::CFG_BASE_SPACE, 8'd0);
		write_reg(cba_pkg::CFG_FREE_CODE, 8'h10);
		write_reg(cba_pkg::CFG_BLOCKS_CODE, 8'h00);
		write_reg(cba_pkg::CFG_RESERVED_CODE, 8'hFF);
		random_phase(140);
		idle_gap(1);

		while (sb.owed.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		$display("sent %0d requests, checked %0d grants: %0d ok, %0d too big, %0d full",
			sent, sb.checked, sb.n_ok, sb.n_big, sb.n_full);
		if (sb.fails == 0 && sb.owed.size() == 0)
			$display("contiguous_block_allocator: match");
		else
			$display("contiguous_block_allocator: mismatch");
		$finish;
	end

endmodule
